### rtl/core/tlfq_pkg.sv
// ----------------------------------------------------------------------------
// tlfq_pkg
// Shared types, constants and helpers of the two-level feedback queue
// scheduler: item structs, op and error codes, controller handshake structs.
// ----------------------------------------------------------------------------
package tlfq_pkg;

    localparam int NUM_PROCS  = 16;
    localparam int PID_W      = 4;
    localparam int SLICE_W    = 16;
    localparam int PTR_W      = $clog2(NUM_PROCS);
    localparam int WALK_MAX   = 2 * NUM_PROCS;
    localparam int STEP_W     = $clog2(WALK_MAX + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SLICE_W-1:0] RESET_FIRST_SLICE = SLICE_W'(4);
    localparam logic [SLICE_W-1:0] RESET_LATER_SLICE = SLICE_W'(2);

    typedef enum logic [1:0] {
        OP_ADMIT  = 2'd0,
        OP_TICK   = 2'd1,
        OP_STATUS = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_FULL   = 2'd1,
        ERR_EMPTY  = 2'd2,
        ERR_NO_RUN = 2'd3
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SLICE = 2'd0,
        CFG_LATER_SLICE = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        logic [PID_W-1:0] proc_id;
        logic             runnable;
    } t_in_item;

    typedef struct packed {
        logic [PID_W-1:0] running_proc;
        logic             switched;
        t_err             error_code;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic dec;
        logic step;
        logic commit;
    } t_tlfq_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_more;
        logic walk_last;
    } t_tlfq_status;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(NUM_PROCS - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### rtl/core/tlfq_dp.sv
// ----------------------------------------------------------------------------
// tlfq_dp
// Scheduler datapath: slice and runnable tables, high and low ring queues,
// walk registers, configuration registers and the result register.
// ----------------------------------------------------------------------------
module tlfq_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tlfq_pkg::t_in_item                   i_in_item,
    input  logic                                 i_cfg_valid,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tlfq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  tlfq_pkg::t_tlfq_cmd                  i_cmd,
    output tlfq_pkg::t_tlfq_status               o_status,
    output tlfq_pkg::t_out_item                  o_out_item
);

    logic [tlfq_pkg::SLICE_W-1:0] r_first_slice;
    logic [tlfq_pkg::SLICE_W-1:0] r_later_slice;
    logic [tlfq_pkg::SLICE_W-1:0] r_slice [tlfq_pkg::NUM_PROCS];
    logic [tlfq_pkg::NUM_PROCS-1:0] r_run;
    logic [tlfq_pkg::PID_W-1:0]   r_high_q [tlfq_pkg::NUM_PROCS];
    logic [tlfq_pkg::PID_W-1:0]   r_low_q  [tlfq_pkg::NUM_PROCS];
    logic [tlfq_pkg::PTR_W-1:0]   r_high_head;
    logic [tlfq_pkg::PTR_W-1:0]   r_high_tail;
    logic [tlfq_pkg::PTR_W-1:0]   r_low_head;
    logic [tlfq_pkg::PTR_W-1:0]   r_low_tail;
    logic [tlfq_pkg::PID_W-1:0]   r_cur_proc;
    logic [tlfq_pkg::PID_W-1:0]   r_cur;
    logic [tlfq_pkg::STEP_W-1:0]  r_steps;
    tlfq_pkg::t_err               r_err;
    tlfq_pkg::t_out_item          r_out_item;

    logic [tlfq_pkg::SLICE_W-1:0] cur_slice;
    logic [tlfq_pkg::PTR_W-1:0]   high_nt;
    logic [tlfq_pkg::PTR_W-1:0]   low_nt;
    logic                         high_full;
    logic                         high_empty;
    logic                         low_full;
    logic                         low_empty;
    logic                         low_empty_after;
    logic                         bound;
    logic [tlfq_pkg::PID_W-1:0]   pop_low_val;

    assign cur_slice       = r_slice[r_cur];
    assign high_nt         = tlfq_pkg::ptr_next(r_high_tail);
    assign low_nt          = tlfq_pkg::ptr_next(r_low_tail);
    assign high_full       = (high_nt == r_high_head);
    assign low_full        = (low_nt == r_low_head);
    assign high_empty      = (r_high_head == r_high_tail);
    assign low_empty       = (r_low_head == r_low_tail);
    // the demoted process lands in the low queue unless that queue is full
    assign low_empty_after = low_empty & low_full;
    assign bound           = (r_steps == tlfq_pkg::STEP_W'(tlfq_pkg::WALK_MAX));
    // an empty low queue gets the demoted process and hands it straight back
    assign pop_low_val     = low_empty ? r_cur : r_low_q[r_low_head];

    assign o_status.walk_more = (cur_slice == '0) || !r_run[r_cur];
    assign o_status.walk_last = bound || (high_empty && low_empty_after);
    assign o_out_item         = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_slice <= tlfq_pkg::RESET_FIRST_SLICE;
            r_later_slice <= tlfq_pkg::RESET_LATER_SLICE;
            for (int i = 0; i < tlfq_pkg::NUM_PROCS; i++) begin
                r_slice[i] <= tlfq_pkg::RESET_FIRST_SLICE;
            end
            r_run       <= tlfq_pkg::NUM_PROCS'(1);
            r_high_head <= '0;
            r_high_tail <= '0;
            r_low_head  <= '0;
            r_low_tail  <= '0;
            r_cur_proc  <= '0;
            r_cur       <= '0;
            r_steps     <= '0;
            r_err       <= tlfq_pkg::ERR_OK;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tlfq_pkg::CFG_FIRST_SLICE: r_first_slice <= i_cfg_data;
                    tlfq_pkg::CFG_LATER_SLICE: r_later_slice <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.start) begin
                r_cur   <= r_cur_proc;
                r_steps <= '0;
                if (i_in_item.op == tlfq_pkg::OP_ADMIT && high_full) begin
                    r_err <= tlfq_pkg::ERR_FULL;
                end else begin
                    r_err <= tlfq_pkg::ERR_OK;
                end
                case (i_in_item.op)
                    tlfq_pkg::OP_ADMIT: begin
                        r_slice[i_in_item.proc_id] <= r_first_slice;
                        r_run[i_in_item.proc_id]   <= 1'b1;
                        if (!high_full) begin
                            r_high_tail <= high_nt;
                        end
                    end
                    tlfq_pkg::OP_STATUS: begin
                        r_run[i_in_item.proc_id] <= i_in_item.runnable;
                    end
                    default: ;
                endcase
            end

            // saturating decrement of the running slice
            if (i_cmd.dec && cur_slice != '0) begin
                r_slice[r_cur] <= cur_slice - 1'b1;
            end

            if (i_cmd.step) begin
                if (bound) begin
                    r_err <= tlfq_pkg::ERR_NO_RUN;
                end else begin
                    r_steps        <= r_steps + 1'b1;
                    r_slice[r_cur] <= r_later_slice;
                    if (!low_full) begin
                        r_low_tail <= low_nt;
                    end
                    if (!high_empty) begin
                        r_cur       <= r_high_q[r_high_head];
                        r_high_head <= tlfq_pkg::ptr_next(r_high_head);
                    end else if (!low_empty_after) begin
                        r_cur      <= pop_low_val;
                        r_low_head <= tlfq_pkg::ptr_next(r_low_head);
                    end
                    // an empty walk outranks a dropped demotion
                    if (high_empty && low_empty_after) begin
                        r_err <= tlfq_pkg::ERR_EMPTY;
                    end else if (low_full) begin
                        r_err <= tlfq_pkg::ERR_FULL;
                    end
                end
            end

            if (i_cmd.commit) begin
                r_cur_proc <= r_cur;
            end
        end
    end

    // queue entries and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_in_item.op == tlfq_pkg::OP_ADMIT && !high_full) begin
            r_high_q[r_high_tail] <= i_in_item.proc_id;
        end
        if (i_cmd.step && !bound && !low_full) begin
            r_low_q[r_low_tail] <= r_cur;
        end
        if (i_cmd.commit) begin
            r_out_item.running_proc <= r_cur;
            r_out_item.switched     <= (r_cur != r_cur_proc);
            r_out_item.error_code   <= r_err;
        end
    end

    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= tlfq_pkg::STEP_W'(tlfq_pkg::WALK_MAX))
        else $error("walk step count past its bound");

    a_start_loads_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_steps == '0) && (r_cur == r_cur_proc))
        else $error("walk registers not loaded at item start");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_out_item.running_proc == r_cur_proc)
                         && (r_cur_proc == $past(r_cur)))
        else $error("result and running process disagree after commit");

endmodule

### rtl/core/tlfq_ctrl.sv
// ----------------------------------------------------------------------------
// tlfq_ctrl
// Scheduler controller: sequences accept, slice decrement, queue walk and
// result commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tlfq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  tlfq_pkg::t_op          i_in_op,
    input  tlfq_pkg::t_tlfq_status i_status,
    output tlfq_pkg::t_tlfq_cmd    o_cmd,
    output logic                   o_out_valid,
    input  logic                   i_out_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEC,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free    = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.start  = o_in_ready && i_in_valid;
    assign o_cmd.dec    = (r_state == S_DEC);
    assign o_cmd.step   = (r_state == S_WALK) && i_status.walk_more;
    assign o_cmd.commit = (r_state == S_DONE) && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.start) begin
                        r_state <= (i_in_op == tlfq_pkg::OP_TICK) ? S_DEC : S_DONE;
                    end
                end
                S_DEC: begin
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // a last step still runs before stopping; at the step bound it sets ERR_NO_RUN instead of demoting
                    if (!i_status.walk_more || i_status.walk_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/two_level_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// two_level_feedback_queue_scheduler
// Two-level feedback queue process scheduler with configurable time slices.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  in        in   i_in_valid / o_in_ready    i_in_item  (op, proc_id, runnable)
//  out       out  o_out_valid / i_out_ready  o_out_item (running_proc, switched,
//                                                        error_code)
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  admit and status items skip the slice decrement and the queue walk
//  a tick decrements the running slice, then takes 0 to 32 queue walk steps, one
//  demote-and-take step per cycle through the slice table and the ring queues
//  one item is in work at a time; a new item is taken while a result waits
//  a stalled result holds the item after it in its final state
//  synchronous active-low reset; the slice table reloads in the reset cycle
// ----------------------------------------------------------------------------
module two_level_feedback_queue_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tlfq_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tlfq_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tlfq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tlfq_pkg::t_tlfq_cmd    cmd;
    tlfq_pkg::t_tlfq_status status;

    assign o_cfg_ready = 1'b1;

    tlfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_op     (i_in_item.op),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    tlfq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

endmodule
